FILE: design/assert_macros.svh
// Assertion macros used by the core design file, ccwd_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ccwd_pkg.sv
// Types, constants and the CRC-8 update function of the checked word deframer.
package ccwd_pkg;

    localparam int MaxEntriesDefault = 16;
    localparam int DataBytes = 4;
    localparam int PosW = 3;
    localparam int EntryW = 4;
    localparam int CountW = 5;

    localparam logic [7:0] CrcPoly = 8'h07;
    localparam logic [7:0] CrcInit = 8'h00;

    typedef struct packed {
        logic [CountW-1:0] entries_in_burst;
        logic              burst_start;
        logic [7:0]        rx_byte;
    } item_t;

    typedef struct packed {
        logic [31:0]       word;
        logic              check_ok;
        logic [EntryW-1:0] entry_index;
        logic [CountW-1:0] good_count;
        logic              burst_done;
    } result_t;

    // One byte through the MSB-first CRC-8 shift register, unrolled.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: design/crc8_checked_word_deframer.sv
// Top level of the CRC-8 checked word deframer.
// The block accepts one byte transfer per cycle and emits one result transfer for every
// fifth byte (four data bytes and the CRC-8 byte of an entry); other bytes emit nothing.
// A byte passes through an input register and then the CRC, counter and word logic into
// the result register, from which the result of an entry's CRC byte is offered.
// Back to back operation at one byte per cycle is held as long as the result side takes
// each result transfer; while a result waits, the input register holds at most one more
// byte, and s_tready stays low while it holds one until the result transfer completes.
module crc8_checked_word_deframer #(
    parameter int MAX_ENTRIES = ccwd_pkg::MaxEntriesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], entries_in_burst[12:8], zeros above
    input  logic [0:0]  s_tuser,   // burst_start[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // word[31:0], entry_index[35:32], good_count[40:36], zeros
    output logic [0:0]  m_tuser,   // check_ok[0]
    output logic        m_tlast
);
    import ccwd_pkg::*;

    item_t   in_item;
    item_t   st_item;
    logic    st_valid;
    logic    st_ready;
    result_t res;

    assign in_item.rx_byte          = s_tdata[7:0];
    assign in_item.entries_in_burst = s_tdata[12:8];
    assign in_item.burst_start      = s_tuser[0];

    ccwd_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (st_valid),
        .out_ready (st_ready),
        .out_item  (st_item)
    );

    ccwd_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid),
        .in_ready  (st_ready),
        .in_item   (st_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {7'd0, res.good_count, res.entry_index, res.word};
    assign m_tuser = res.check_ok;
    assign m_tlast = res.burst_done;

    // Bits 15:13 of s_tdata are padding and carry nothing.

endmodule

FILE: design/ccwd_in_stage.sv
// Input register stage that holds one accepted byte transfer.
module ccwd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ccwd_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output ccwd_pkg::item_t out_item
);
    import ccwd_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: design/ccwd_core.sv
// Entry assembly, CRC check, burst counters and the result register.
`include "assert_macros.svh"

module ccwd_core #(
    parameter int MAX_ENTRIES = ccwd_pkg::MaxEntriesDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ccwd_pkg::item_t   in_item,
    output logic             res_valid,
    input  logic             res_ready,
    output ccwd_pkg::result_t res
);
    import ccwd_pkg::*;

    localparam int TargetMax = (MAX_ENTRIES > 31) ? 31 : MAX_ENTRIES;

    logic [PosW-1:0]   pos_reg, pos_next;
    logic [31:0]       word_reg, word_next;
    logic [7:0]        crc_reg, crc_next;
    logic [EntryW-1:0] entry_reg, entry_next;
    logic [CountW-1:0] seen_reg, seen_next;
    logic [CountW-1:0] good_reg, good_next;
    logic [CountW-1:0] target_reg, target_next;
    logic              out_valid_reg;
    result_t           out_reg;

    logic [PosW-1:0]   eff_pos;
    logic [31:0]       eff_word;
    logic [7:0]        eff_crc;
    logic [EntryW-1:0] eff_entry;
    logic [CountW-1:0] eff_seen;
    logic [CountW-1:0] eff_good;
    logic [CountW-1:0] want_sat;
    logic              take;
    logic              is_check;
    logic              ok;
    logic              last;
    logic [CountW-1:0] good_inc;
    result_t           result;

    assign in_ready  = !out_valid_reg || res_ready;
    assign take      = in_valid && in_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        if (in_item.entries_in_burst == '0)
        begin
            want_sat = CountW'(1);
        end
        else if (int'(in_item.entries_in_burst) > TargetMax)
        begin
            want_sat = CountW'(TargetMax);
        end
        else
        begin
            want_sat = in_item.entries_in_burst;
        end

        eff_pos     = in_item.burst_start ? '0 : pos_reg;
        eff_word    = in_item.burst_start ? '0 : word_reg;
        eff_crc     = in_item.burst_start ? CrcInit : crc_reg;
        eff_entry   = in_item.burst_start ? '0 : entry_reg;
        eff_seen    = in_item.burst_start ? '0 : seen_reg;
        eff_good    = in_item.burst_start ? '0 : good_reg;
        target_next = in_item.burst_start ? want_sat : target_reg;

        is_check = (eff_pos >= PosW'(DataBytes));
        ok       = (in_item.rx_byte == eff_crc);
        good_inc = eff_good + CountW'(ok);
        last     = ({1'b0, eff_seen} + 6'd1) >= {1'b0, target_next};

        result.word        = eff_word;
        result.check_ok    = ok;
        result.entry_index = eff_entry;
        result.good_count  = good_inc;
        result.burst_done  = last;

        if (!is_check)
        begin
            pos_next   = eff_pos + PosW'(1);
            word_next  = {eff_word[23:0], in_item.rx_byte};
            crc_next   = crc8_update(eff_crc, in_item.rx_byte);
            entry_next = eff_entry;
            seen_next  = eff_seen;
            good_next  = eff_good;
        end
        else
        begin
            pos_next  = '0;
            word_next = '0;
            crc_next  = CrcInit;
            if (last)
            begin
                entry_next = '0;
                seen_next  = '0;
                good_next  = '0;
            end
            else
            begin
                entry_next = eff_entry + EntryW'(1);
                seen_next  = eff_seen + CountW'(1);
                good_next  = good_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            word_reg      <= '0;
            crc_reg       <= CrcInit;
            entry_reg     <= '0;
            seen_reg      <= '0;
            good_reg      <= '0;
            target_reg    <= CountW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pos_reg    <= pos_next;
                word_reg   <= word_next;
                crc_reg    <= crc_next;
                entry_reg  <= entry_next;
                seen_reg   <= seen_next;
                good_reg   <= good_next;
                target_reg <= target_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= take && is_check;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && is_check)
        begin
            out_reg <= result;
        end
    end

    `ASSERT_ALWAYS(a_pos_range, clk, rst_n, pos_reg <= PosW'(DataBytes), "byte position out of range")
    `ASSERT_ALWAYS(a_good_le_seen, clk, rst_n, good_reg <= seen_reg, "good count exceeds entries")
    `ASSERT_ALWAYS(a_seen_lt_target, clk, rst_n, seen_reg < target_reg, "entry count passed target")
    `ASSERT_NEXT(a_done_clears, clk, rst_n, take && is_check && last, seen_reg == '0 && good_reg == '0, "burst counters not cleared")

endmodule

FILE: tb/crc8_checked_word_deframer_tb.sv
// Self-checking testbench for the CRC-8 checked word deframer, predicting each result transfer.
`timescale 1ns / 1ps

module crc8_checked_word_deframer_tb;

    import ccwd_pkg::*;

    localparam int MAX_BURST_ENTRIES = MaxEntriesDefault;
    localparam logic [7:0] CRC8_POLY = 8'h07;
    localparam logic [7:0] CRC8_SEED = 8'h00;
    localparam int CRC_BYTE_POS = 4;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    item_t   pending_bytes[$];
    result_t expected_entries[$];
    item_t   bus_byte;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatches = 0;
    int queued_bytes = 0;

    logic [2:0]  byte_pos = '0;
    logic [31:0] shift_word = '0;
    logic [7:0]  crc_acc = CRC8_SEED;
    logic [3:0]  entry_idx = '0;
    logic [4:0]  done_entries = '0;
    logic [4:0]  good_entries = '0;
    logic [4:0]  burst_len = 5'd1;

    crc8_checked_word_deframer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // Bit-serial CRC-8: each message bit is folded into the top of the register.
    function automatic logic [7:0] crc8_of(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            if (r[7] ^ b[i])
            begin
                r = {r[6:0], 1'b0} ^ CRC8_POLY;
            end
            else
            begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

    task automatic clear_burst_state();
        byte_pos = '0;
        shift_word = '0;
        crc_acc = CRC8_SEED;
        entry_idx = '0;
        done_entries = '0;
        good_entries = '0;
    endtask

    task automatic predict_deframe(input item_t it);
        logic [4:0] want;
        result_t r;
        if (it.burst_start)
        begin
            clear_burst_state();
            want = it.entries_in_burst;
            if (want == 0)
            begin
                want = 5'd1;
            end
            if (int'(want) > MAX_BURST_ENTRIES)
            begin
                want = 5'(MAX_BURST_ENTRIES);
            end
            burst_len = want;
        end
        if (int'(byte_pos) < CRC_BYTE_POS)
        begin
            shift_word = {shift_word[23:0], it.rx_byte};
            crc_acc = crc8_of(crc_acc, it.rx_byte);
            byte_pos = byte_pos + 3'd1;
        end
        else
        begin
            r.check_ok = (it.rx_byte == crc_acc);
            if (r.check_ok)
            begin
                good_entries = good_entries + 5'd1;
            end
            r.word = shift_word;
            r.entry_index = entry_idx;
            r.good_count = good_entries;
            r.burst_done = (int'(done_entries) + 1 >= int'(burst_len));
            expected_entries.push_back(r);
            byte_pos = '0;
            shift_word = '0;
            crc_acc = CRC8_SEED;
            if (r.burst_done)
            begin
                clear_burst_state();
            end
            else
            begin
                entry_idx = entry_idx + 4'd1;
                done_entries = done_entries + 5'd1;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_deframe(bus_byte);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    bus_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b000, bus_byte.entries_in_burst, bus_byte.rx_byte};
                    s_tuser <= bus_byte.burst_start;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            if (m_tvalid && m_tready)
            begin
                if (expected_entries.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected transfer, expected none, actual word %h",
                             $time, m_tdata[31:0]);
                end
                else
                begin
                    e = expected_entries.pop_front();
                    check_field("word", e.word, m_tdata[31:0]);
                    check_field("check_ok", 32'(e.check_ok), 32'(m_tuser[0]));
                    check_field("entry_index", 32'(e.entry_index), 32'(m_tdata[35:32]));
                    check_field("good_count", 32'(e.good_count), 32'(m_tdata[40:36]));
                    check_field("burst_done", 32'(e.burst_done), 32'(m_tlast));
                end
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic start, input logic [4:0] len);
        item_t it;
        it.rx_byte = b;
        it.burst_start = start;
        it.entries_in_burst = len;
        pending_bytes.push_back(it);
        queued_bytes++;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0)
        begin
            return 8'h00;
        end
        if (r == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    // Four data bytes and a CRC byte that is correct unless corrupt is set.
    task automatic queue_entry(input logic start, input logic [4:0] len, input logic corrupt);
        logic [7:0] acc;
        logic [7:0] b;
        acc = CRC8_SEED;
        for (int k = 0; k < 4; k++)
        begin
            b = pick_byte();
            queue_byte(b, start && k == 0, (start && k == 0) ? len : 5'($urandom));
            acc = crc8_of(acc, b);
        end
        queue_byte(corrupt ? pick_byte() : acc, 1'b0, 5'($urandom));
    endtask

    function automatic int effective_len(input logic [4:0] len);
        if (len == 0)
        begin
            return 1;
        end
        return (int'(len) > MAX_BURST_ENTRIES) ? MAX_BURST_ENTRIES : int'(len);
    endfunction

    task automatic queue_random_traffic(input int count);
        int r;
        int n;
        logic [4:0] len;
        while (queued_bytes < count)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                n = $urandom_range(99);
                if (n < 80)
                begin
                    len = 5'($urandom_range(1, 4));
                end
                else if (n < 92)
                begin
                    len = 5'($urandom_range(5, 16));
                end
                else
                begin
                    len = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
                end
                for (int e = 0; e < effective_len(len); e++)
                begin
                    queue_entry(e == 0, len, $urandom_range(99) < 25);
                end
            end
            else if (r < 80)
            begin
                len = 5'($urandom);
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++)
                begin
                    queue_byte(pick_byte(), k == 0, len);
                end
            end
            else if (r < 90)
            begin
                queue_entry(1'b0, 5'($urandom), $urandom_range(99) < 25);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                begin
                    queue_byte(pick_byte(), $urandom_range(7) == 0, 5'($urandom));
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_tvalid || expected_entries.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        queued_bytes = 0;
        queue_random_traffic(count);
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Entry before any burst start, then bursts with zero, oversized and mid-entry restarts.
        queue_entry(1'b0, 5'd0, 1'b0);
        queue_byte(8'hFF, 1'b1, 5'd0);
        queue_byte(8'hFF, 1'b0, 5'd31);
        queue_byte(8'hFF, 1'b0, 5'd31);
        queue_byte(8'hFF, 1'b0, 5'd31);
        queue_byte(8'hFF, 1'b0, 5'd31);
        queue_byte(8'h00, 1'b1, 5'd31);
        queue_byte(8'h00, 1'b0, 5'd0);
        queue_byte(8'h00, 1'b0, 5'd0);
        queue_byte(8'h00, 1'b0, 5'd0);
        queue_byte(8'h00, 1'b0, 5'd0);
        queue_byte(8'hA5, 1'b1, 5'd17);
        queue_byte(8'h5A, 1'b0, 5'd16);
        queue_entry(1'b1, 5'd2, 1'b0);
        queue_entry(1'b0, 5'd1, 1'b1);
        wait_drained();

        run_phase(0, 0, 335);
        run_phase(83, 0, 330);
        run_phase(0, 83, 330);
        run_phase(13, 13, 335);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_entries.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected transfers never arrived", $time,
                     expected_entries.size());
        end
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
